// File: hw/rtl/bounded_unique_pair_table_core_defines.svh
// ----------------------------------------------------------------------------
// Bounded unique pair table: assertion macros
// Shared concurrent assertion forms, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_UNIQUE_PAIR_TABLE_CORE_DEFINES_SVH
`define BOUNDED_UNIQUE_PAIR_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define BUPT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BUPT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/bupt_pkg.sv
// ----------------------------------------------------------------------------
// bupt_pkg
// Sizes, codes and request/response types of the bounded unique pair table.
// ----------------------------------------------------------------------------
`default_nettype none

package bupt_pkg;

    localparam int MAX_ENTRIES  = 16;
    localparam int FIRST_WIDTH  = 32;
    localparam int SECOND_WIDTH = 32;

    localparam int PAIR_W = FIRST_WIDTH + SECOND_WIDTH;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    localparam int OP_W     = 2;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] first_value;
        logic [VAL_W-1:0] second_value;
        logic [POS_W-1:0] position;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  entry_count;
        logic [VAL_W-1:0]    read_first;
        logic [VAL_W-1:0]    read_second;
    } rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/bounded_unique_pair_table_core.sv
// Add scans the stored pairs for a duplicate, then appends; remove shifts later entries down;
//   read fetches the pair at the position; refused or unused operations go straight to the response.
// One request at a time; the next is accepted once the response is registered.
// Duplicate scan and remove shift run at one memory read per cycle.
// Reset clears the count and handshake state; the pair memory is not cleared.
// ----------------------------------------------------------------------------
// bounded_unique_pair_table_core
// Ordered table of unique pairs held in a one-port-read synchronous memory.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_unique_pair_table_core_defines.svh"

module bounded_unique_pair_table_core
    import bupt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_RDREQ = 3'd3;
    localparam logic [2:0] S_RDRSP = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [IDX_W-1:0]        dst_reg, dst_next;
    logic                    rdv_reg, rdv_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic [PAIR_W-1:0]       pair_reg, pair_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [FIRST_WIDTH-1:0]  rf_reg, rf_next;
    logic [SECOND_WIDTH-1:0] rs_reg, rs_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_t                    rsp_reg, rsp_next;

    logic [PAIR_W-1:0]       mem [MAX_ENTRIES];
    logic [PAIR_W-1:0]       rd_data;
    logic                    mem_rd_en, mem_wr_en;
    logic [IDX_W-1:0]        mem_rd_addr, mem_wr_addr;
    logic [PAIR_W-1:0]       mem_wr_data;

    logic                    req_fire;
    logic                    badpos;
    logic                    rsp_free;

    assign req_stall = (state_reg != S_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign badpos    = (CNT_W + POS_W)'(req.position) >= (CNT_W + POS_W)'(count_reg);

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rd_data <= mem[mem_rd_addr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        dst_next       = dst_reg;
        rdv_next       = 1'b0;
        op_next        = op_reg;
        pair_next      = pair_reg;
        pos_next       = pos_reg;
        status_next    = status_reg;
        rf_next        = rf_reg;
        rs_next        = rs_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = '0;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = '0;
        mem_wr_data    = pair_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    op_next     = req.op;
                    pair_next   = {FIRST_WIDTH'(req.first_value),
                                   SECOND_WIDTH'(req.second_value)};
                    pos_next    = req.position;
                    status_next = ST_OK;
                    rf_next     = '0;
                    rs_next     = '0;
                    case (req.op)
                        OP_ADD:
                        begin
                            if (count_reg >= CNT_W'(MAX_ENTRIES))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (badpos)
                            begin
                                status_next = ST_BADPOS;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                idx_next   = CNT_W'(req.position) + CNT_W'(1);
                                dst_next   = IDX_W'(req.position);
                                state_next = S_SHIFT;
                            end
                        end
                        OP_READ:
                        begin
                            if (badpos)
                            begin
                                status_next = ST_BADPOS;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_RDREQ;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (rdv_reg && (rd_data == pair_reg))
                begin
                    status_next = ST_DUP;
                    state_next  = S_DONE;
                end
                else if (idx_reg == count_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = IDX_W'(count_reg);
                    count_next  = count_reg + CNT_W'(1);
                    state_next  = S_DONE;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_reg[IDX_W-1:0];
                    idx_next    = idx_reg + CNT_W'(1);
                    rdv_next    = 1'b1;
                end
            end
            S_SHIFT:
            begin
                if (rdv_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = dst_reg;
                    mem_wr_data = rd_data;
                    dst_next    = dst_reg + IDX_W'(1);
                end
                if (idx_reg < count_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_reg[IDX_W-1:0];
                    idx_next    = idx_reg + CNT_W'(1);
                    rdv_next    = 1'b1;
                end
                else if (!rdv_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end
            S_RDREQ:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = IDX_W'(pos_reg);
                state_next  = S_RDRSP;
            end
            S_RDRSP:
            begin
                rf_next    = rd_data[PAIR_W-1:SECOND_WIDTH];
                rs_next    = rd_data[SECOND_WIDTH-1:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_next.status      = status_reg;
                    rsp_next.entry_count = COUNT_W'(count_reg);
                    rsp_next.read_first  = VAL_W'(rf_reg);
                    rsp_next.read_second = VAL_W'(rs_reg);
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            dst_reg       <= '0;
            rdv_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            dst_reg       <= dst_next;
            rdv_reg       <= rdv_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        pair_reg   <= pair_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        rf_reg     <= rf_next;
        rs_reg     <= rs_next;
        rsp_reg    <= rsp_next;
    end

    `BUPT_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1,
        count_reg <= CNT_W'(MAX_ENTRIES), "count over max")
    `BUPT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, req_fire,
        state_reg != S_IDLE, "not busy after accept")
    `BUPT_ASSERT_IMP(a_no_idle_write, clk, rst_n, mem_wr_en,
        (state_reg == S_SCAN) || (state_reg == S_SHIFT), "memory write outside scan or shift")
    `BUPT_ASSERT_NXT(a_count_step, clk, rst_n, 1'b1,
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + CNT_W'(1)) ||
        (count_reg == $past(count_reg) - CNT_W'(1)), "count jumped")
    `BUPT_ASSERT_NXT(a_rsp_issue, clk, rst_n, (state_reg == S_DONE) && rsp_free,
        rsp_valid_reg && (state_reg == S_IDLE), "response not issued")

endmodule

`default_nettype wire
